// File: design/dq_pkg.sv
// dq_pkg: shared types and constants for the double-ended queue.
// Request and status codes, field widths, controller/datapath interface structs.
// No dependencies.
package dq_pkg;

	localparam int VALUE_W  = 32;
	localparam int REQ_W    = 3;
	localparam int STATUS_W = 2;

	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_LIST       = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic exec;       // apply accepted push/pop, empty-list or unused-code request
		logic list_clr;   // start a listing at the front element
		logic list_rd;    // read ring entry at the list position
		logic list_load;  // move read data into the output register
		logic list_next;  // advance list position
	} dq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;   // output register can take a result this cycle
		logic empty;
		logic list_last;  // list position is at the back element
	} dq_stat_t;

endpackage

// File: design/dq_ctrl.sv
// dq_ctrl: request sequencer for the double-ended queue.
// Drives dq_cmd_t to the datapath from dq_stat_t; uses dq_pkg.
module dq_ctrl import dq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [REQ_W-1:0] req_type,
	input  dq_stat_t         stat,
	output dq_cmd_t          cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_LOAD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign in_ready = (state_q == S_IDLE) && stat.out_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_type == REQ_LIST && !stat.empty) begin
						cmd.list_clr = 1'b1;
						state_d      = S_READ;
					end else begin
						cmd.exec = 1'b1;
					end
				end
			end
			S_READ: begin
				cmd.list_rd = 1'b1;
				state_d     = S_LOAD;
			end
			S_LOAD: begin
				if (stat.out_free) begin
					cmd.list_load = 1'b1;
					if (stat.list_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.list_next = 1'b1;
						state_d       = S_READ;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: design/dq_dp.sv
// dq_dp: ring store, front index, entry count, list position and output register.
// Acts on dq_cmd_t from dq_ctrl; uses dq_pkg.
module dq_dp import dq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [VALUE_W-1:0]  value,
	input  dq_cmd_t             cmd,
	output dq_stat_t            stat,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [VALUE_W-1:0]  item_value,
	output logic [STATUS_W-1:0] status,
	output logic                last
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	logic [VALUE_W-1:0]  mem_q [DEPTH];
	logic [VALUE_W-1:0]  rd_data_q;
	logic [IDX_W-1:0]    front_q, front_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [IDX_W-1:0]    idx_q;
	logic                out_valid_q;
	logic [VALUE_W-1:0]  item_value_q;
	logic [STATUS_W-1:0] status_q;
	logic                last_q;

	logic                full, empty;
	logic [IDX_W-1:0]    front_dec, front_inc, back_slot, rd_addr;
	logic [SUM_W-1:0]    back_sum, rd_sum;
	logic                we;
	logic [IDX_W-1:0]    waddr;
	logic                res_load;
	logic [STATUS_W-1:0] res_status;
	logic                load;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;

	// ring wrap: sum stays below twice the depth
	assign back_sum  = SUM_W'(front_q) + SUM_W'(count_q);
	assign back_slot = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
	                                               : back_sum[IDX_W-1:0];
	assign rd_sum    = SUM_W'(front_q) + SUM_W'(idx_q);
	assign rd_addr   = (rd_sum >= SUM_W'(DEPTH)) ? IDX_W'(rd_sum - SUM_W'(DEPTH))
	                                             : rd_sum[IDX_W-1:0];

	always_comb begin
		front_d    = front_q;
		count_d    = count_q;
		we         = 1'b0;
		waddr      = back_slot;
		res_load   = 1'b0;
		res_status = ST_OK;
		if (cmd.exec) begin
			case (req_type)
				REQ_PUSH_FRONT: begin
					res_load = 1'b1;
					if (full) begin
						res_status = ST_FULL;
					end else begin
						we      = 1'b1;
						waddr   = front_dec;
						front_d = front_dec;
						count_d = count_q + 1'b1;
					end
				end
				REQ_PUSH_BACK: begin
					res_load = 1'b1;
					if (full) begin
						res_status = ST_FULL;
					end else begin
						we      = 1'b1;
						count_d = count_q + 1'b1;
					end
				end
				REQ_POP_FRONT: begin
					res_load = 1'b1;
					if (empty) begin
						res_status = ST_EMPTY;
					end else begin
						front_d = front_inc;
						count_d = count_q - 1'b1;
					end
				end
				REQ_POP_BACK: begin
					res_load = 1'b1;
					if (empty) begin
						res_status = ST_EMPTY;
					end else begin
						count_d = count_q - 1'b1;
					end
				end
				REQ_LIST: begin
					// only reaches exec when the store is empty
					res_load   = 1'b1;
					res_status = ST_EMPTY;
				end
				default: begin
					res_load = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.list_rd) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign load = res_load || cmd.list_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			front_q <= front_d;
			count_q <= count_d;
			if (cmd.list_clr) begin
				idx_q <= '0;
			end else if (cmd.list_next) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			item_value_q <= '0;
			status_q     <= res_status;
			last_q       <= 1'b1;
		end else if (cmd.list_load) begin
			item_value_q <= rd_data_q;
			status_q     <= ST_OK;
			last_q       <= stat.list_last;
		end
	end

	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.empty     = empty;
	assign stat.list_last = (CNT_W'(idx_q) == count_q - 1'b1);

	assign out_valid  = out_valid_q;
	assign item_value = item_value_q;
	assign status     = status_q;
	assign last       = last_q;

endmodule

// File: design/double_ended_queue.sv
// Double-ended queue of signed 32-bit values in a ring store of DEPTH entries.
// Input channel (in_valid/in_ready): one request per handshake, req_type selects
// push front, push back, pop front, pop back or list; value is used by pushes.
// Output channel (out_valid/out_ready): item_value, status, last per result.
// A push or pop gives one result (item_value zero, status ok/empty/full) that
// appears in the output register the cycle after the request is taken; another
// push or pop can be taken each cycle while results are drained.
// A list request gives one result per element, front first, last set on the
// final one; each element is read from the ring (S_READ), then loaded into the
// output register (S_LOAD), one at a time through the single ring read port;
// the input is held off until the final element is loaded.
// Listing an empty store gives one empty-status result. Codes 5 to 7 are taken
// and give no result.
// While out_ready is low the output register holds its result and in_ready
// drops; no result is lost. Reset (arst_n low) empties the queue and clears the
// output valid flag; ring contents are not cleared and need no sweep.
// Uses dq_pkg, dq_ctrl and dq_dp.
module double_ended_queue import dq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [VALUE_W-1:0]  value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [VALUE_W-1:0]  item_value,
	output logic [STATUS_W-1:0] status,
	output logic                last
);

	dq_cmd_t  cmd;
	dq_stat_t stat;

	dq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd)
	);

	dq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_type   (req_type),
		.value      (value),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.item_value (item_value),
		.status     (status),
		.last       (last)
	);

endmodule

// File: dv/dq_checker.sv
// dq_checker: watches both request and result channels of double_ended_queue,
// predicts the result stream with its own deque copy and compares field by field.
// Depends on dq_pkg for request and status codes and field widths.
`timescale 1ns / 1ps
module dq_checker import dq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [VALUE_W-1:0]  value,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [VALUE_W-1:0]  item_value,
	input  logic [STATUS_W-1:0] status,
	input  logic                last,
	output int                  fail_count,
	output int                  pending,
	output int                  req_count,
	output int                  result_count,
	output int                  full_seen,
	output int                  empty_seen
);

	typedef struct packed {
		logic [VALUE_W-1:0]  item;
		logic [STATUS_W-1:0] st;
		logic                lst;
	} dq_result_t;

	logic [VALUE_W-1:0] ring_copy [DEPTH];
	int                 front_slot;
	int                 fill_level;
	dq_result_t         expected_results [$];

	// Applies one request to the deque copy and queues the results it causes.
	task automatic predict_outcomes(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val);
		int slot;
		case (req)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (fill_level == DEPTH) begin
					expected_results.push_back('{item: '0, st: ST_FULL, lst: 1'b1});
				end else begin
					if (req == REQ_PUSH_FRONT) begin
						front_slot = (front_slot + DEPTH - 1) % DEPTH;
						slot = front_slot;
					end else begin
						slot = (front_slot + fill_level) % DEPTH;
					end
					ring_copy[slot] = val;
					fill_level++;
					expected_results.push_back('{item: '0, st: ST_OK, lst: 1'b1});
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (fill_level == 0) begin
					expected_results.push_back('{item: '0, st: ST_EMPTY, lst: 1'b1});
				end else begin
					if (req == REQ_POP_FRONT)
						front_slot = (front_slot + 1) % DEPTH;
					fill_level--;
					expected_results.push_back('{item: '0, st: ST_OK, lst: 1'b1});
				end
			end
			REQ_LIST: begin
				if (fill_level == 0) begin
					expected_results.push_back('{item: '0, st: ST_EMPTY, lst: 1'b1});
				end else begin
					for (int i = 0; i < fill_level; i++)
						expected_results.push_back('{item: ring_copy[(front_slot + i) % DEPTH],
							st: ST_OK, lst: (i == fill_level - 1)});
				end
			end
			default: begin
				// unused codes are swallowed without a result
			end
		endcase
	endtask

	task automatic compare_result();
		dq_result_t want;
		result_count++;
		if (status == ST_FULL)
			full_seen++;
		if (status == ST_EMPTY)
			empty_seen++;
		if (expected_results.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: unexpected result item_value=%h status=%0d last=%b",
					$realtime, item_value, status, last);
		end else begin
			want = expected_results.pop_front();
			if (item_value !== want.item || status !== want.st || last !== want.lst) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: mismatch item_value %h/%h status %0d/%0d last %b/%b (exp/got)",
						$realtime, want.item, item_value, want.st, status, want.lst, last);
			end
		end
	endtask

	// Result side first: a result never belongs to a request taken on the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			front_slot   = 0;
			fill_level   = 0;
			fail_count   = 0;
			pending      = 0;
			req_count    = 0;
			result_count = 0;
			full_seen    = 0;
			empty_seen   = 0;
		end else begin
			if (out_valid && out_ready)
				compare_result();
			if (in_valid && in_ready) begin
				req_count++;
				predict_outcomes(req_type, value);
			end
			pending = expected_results.size();
		end
	end

endmodule

// File: dv/tb_top.sv
// tb_top: drives requests into double_ended_queue with random gaps and result stalls,
// directed corner cases first, then shaped random fill/drain/list sequences.
// Depends on dq_pkg, double_ended_queue and dq_checker.
`timescale 1ns / 1ps
module tb_top;
	import dq_pkg::*;

	localparam int DEPTH        = 16;
	localparam int RANDOM_ITEMS = 320;
	localparam int QUIET_TAIL   = 60;
	localparam int LONG_STALL   = 300;

	localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
	localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [REQ_W-1:0]    req_type;
	logic [VALUE_W-1:0]  value;
	logic                out_valid;
	logic                out_ready;
	logic [VALUE_W-1:0]  item_value;
	logic [STATUS_W-1:0] status;
	logic                last;

	int fail_count, pending, req_count, result_count, full_seen, empty_seen;

	logic quiet;          // no idling on either side
	logic hold_off_req;   // asks the result side for one long stall
	int   sent;           // requests with a valid code taken so far

	double_ended_queue #(.DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.item_value(item_value), .status(status), .last(last)
	);

	dq_checker #(.DEPTH(DEPTH)) checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.item_value(item_value), .status(status), .last(last),
		.fail_count(fail_count), .pending(pending), .req_count(req_count),
		.result_count(result_count), .full_seen(full_seen), .empty_seen(empty_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [VALUE_W-1:0] random_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken, or after a random idle gap.
	task automatic send_request(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val);
		in_valid <= 1'b1;
		req_type <= req;
		value    <= val;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (req <= REQ_LIST)
			sent++;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			req_type <= REQ_W'($urandom);
			value    <= $urandom;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
	endtask

	task automatic drain_pause();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	// result-side back-pressure
	initial begin
		bit long_done;
		long_done = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off_req && !long_done) begin
				long_done = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_STALL) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(negedge clk);
			end
		end
	end

	initial begin
		int  rand_start;
		bit  held, drained;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		req_type     = REQ_PUSH_FRONT;
		value        = '0;
		quiet        = 1'b0;
		hold_off_req = 1'b0;
		sent         = 0;
		held         = 0;
		drained      = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty store corners, ignored code, extremes
		send_request(REQ_LIST, random_value());
		send_request(REQ_POP_FRONT, random_value());
		send_request(REQ_POP_BACK, random_value());
		send_request(REQ_UNUSED_LO, random_value());
		send_request(REQ_UNUSED_HI, random_value());
		send_request(REQ_PUSH_FRONT, 32'h8000_0000);
		send_request(REQ_PUSH_BACK, 32'h7fff_ffff);
		send_request(REQ_LIST, random_value());
		send_request(REQ_POP_FRONT, random_value());
		send_request(REQ_POP_BACK, random_value());
		// fill to the bound from both ends so the ring wraps, then push into a full store
		for (int i = 0; i < DEPTH; i++)
			send_request((i % 2) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, random_value());
		send_request(REQ_PUSH_FRONT, random_value());
		send_request(REQ_PUSH_BACK, random_value());
		send_request(REQ_LIST, random_value());

		rand_start = sent;
		while (sent < rand_start + RANDOM_ITEMS) begin
			if (!held && sent >= rand_start + 100) begin
				hold_off_req = 1'b1;
				held = 1;
			end
			if (!drained && sent >= rand_start + 200) begin
				drain_pause();
				drained = 1;
			end
			if (sent >= rand_start + RANDOM_ITEMS - QUIET_TAIL)
				quiet = 1'b1;
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					repeat ($urandom_range(4, 20))
						send_request(REQ_W'($urandom_range(REQ_PUSH_FRONT, REQ_PUSH_BACK)),
							random_value());
				end
				3, 4: begin
					repeat ($urandom_range(4, 20))
						send_request(REQ_W'($urandom_range(REQ_POP_FRONT, REQ_POP_BACK)),
							random_value());
				end
				5, 6, 7: begin
					repeat (8)
						send_request(REQ_W'($urandom_range(REQ_PUSH_FRONT, REQ_LIST)),
							random_value());
				end
				8: begin
					send_request(REQ_LIST, random_value());
				end
				default: begin
					repeat ($urandom_range(1, 3))
						send_request(REQ_W'($urandom_range(REQ_PUSH_FRONT, REQ_UNUSED_HI)),
							random_value());
				end
			endcase
		end

		in_valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		repeat (2 * DEPTH + 10) @(posedge clk);

		$display("Run took %0d requests and checked %0d results (%0d full, %0d empty status).",
			req_count, result_count, full_seen, empty_seen);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
